// ===== rtl/wide_bit_vector_alu_assert.svh =====
// Assertion macros shared by the wide bit vector ALU modules.
`ifndef WIDE_BIT_VECTOR_ALU_ASSERT_SVH
`define WIDE_BIT_VECTOR_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WBVA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define WBVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wbva_pkg.sv =====
// Shared types and constants for the wide bit vector ALU.
`default_nettype none

package wbva_pkg;

  localparam int unsigned WORD_W = 64;

  typedef enum logic [3:0] {
    CMD_CLEAR  = 4'd0,
    CMD_SETBIT = 4'd1,
    CMD_CLRBIT = 4'd2,
    CMD_GETBIT = 4'd3,
    CMD_WRWORD = 4'd4,
    CMD_RDWORD = 4'd5,
    CMD_SHL    = 4'd6,
    CMD_SHR    = 4'd7,
    CMD_NOT    = 4'd8,
    CMD_AND    = 4'd9,
    CMD_OR     = 4'd10,
    CMD_XOR    = 4'd11,
    CMD_ADD    = 4'd12,
    CMD_SUB    = 4'd13
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WORD_EXEC,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic word_rd;
    logic word_exec;
    logic sweep_rd;
    logic sweep_wr;
    logic finish;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic word_go;
    logic sweep_go;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/wide_bit_vector_alu.sv =====
// Top level of the wide bit vector ALU.
//
// Holds a bit vector of NBLOCKS 64-bit words. A command word is taken at a
// rising edge where start is high and busy is low; command, position,
// operand_word and shift_amount are sampled at that edge only.
// Every command gives exactly one result word: read_data and carry_out are
// valid for the single cycle in which done is high. The receiver has no
// way to hold results off, so nothing waits on it.
// Steps, from the accepting edge to done:
//   bit and word commands: dispatch, registered store read, compute and
//     write back; a new command may be taken in the done cycle.
//   clear, out-of-range positions, unused codes, shifts past the capacity:
//     dispatch, then finish.
//   shl, shr, not: dispatch, a sweep over every word, then finish; the word
//     store has one write port, so each word is read and then written back.
// Reset (rst, synchronous) returns the controller to idle, drops done,
// clears the carry, and marks every word as zero through per-word valid bits.
`default_nettype none

module wide_bit_vector_alu import wbva_pkg::*; #(
  parameter int unsigned NBLOCKS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        command,
  input  logic [7:0]        position,
  input  logic [WORD_W-1:0] operand_word,
  input  logic [8:0]        shift_amount,
  output logic              done,
  output logic [WORD_W-1:0] read_data,
  output logic              carry_out
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequence each command: dispatch, then a word step, a sweep and finish, or finish alone.
  wbva_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Hold the vector and carry, and form the result word.
  wbva_dpath #(
    .NBLOCKS (NBLOCKS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .position     (position),
    .operand_word (operand_word),
    .shift_amount (shift_amount),
    .read_data    (read_data),
    .carry_out    (carry_out),
    .done         (done)
  );

endmodule

`default_nettype wire

// ===== rtl/wbva_ctrl.sv =====
// Controller state machine of the wide bit vector ALU.
`default_nettype none
`include "wide_bit_vector_alu_assert.svh"

module wbva_ctrl import wbva_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.word_go) begin
          state_next = ST_WORD_EXEC;
        end else if (stat.sweep_go) begin
          state_next = ST_SWEEP_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_WORD_EXEC: state_next = ST_IDLE;
      ST_SWEEP_RD:  state_next = ST_SWEEP_WR;
      ST_SWEEP_WR: begin
        if (stat.sweep_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SWEEP_RD;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      ST_DISPATCH:  ctrl.word_rd   = stat.word_go;
      ST_WORD_EXEC: ctrl.word_exec = 1'b1;
      ST_SWEEP_RD:  ctrl.sweep_rd  = 1'b1;
      ST_SWEEP_WR:  ctrl.sweep_wr  = 1'b1;
      ST_FINISH:    ctrl.finish    = 1'b1;
      default:      busy           = 1'b1;
    endcase
  end

  `WBVA_ASSERT_NEXT(a_sweep_end, ctrl.sweep_wr && stat.sweep_last, ctrl.finish, "sweep did not finish after last word")
  `WBVA_ASSERT_NEXT(a_exec_returns, ctrl.word_exec, !busy, "controller not idle after word step")

endmodule

`default_nettype wire

// ===== rtl/wbva_dpath.sv =====
// Datapath of the wide bit vector ALU: word store, shift and word units.
`default_nettype none
`include "wide_bit_vector_alu_assert.svh"

module wbva_dpath import wbva_pkg::*; #(
  parameter int unsigned NBLOCKS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic [3:0]        command,
  input  logic [7:0]        position,
  input  logic [WORD_W-1:0] operand_word,
  input  logic [8:0]        shift_amount,
  output logic [WORD_W-1:0] read_data,
  output logic              carry_out,
  output logic              done
);

  localparam int unsigned AW  = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
  localparam int unsigned SW  = AW + 4;
  localparam int unsigned CW  = ($clog2(NBLOCKS * 64) + 1 > 9) ?
                                ($clog2(NBLOCKS * 64) + 1) : 9;
  localparam logic [CW-1:0] CAP = CW'(NBLOCKS * 64);
  localparam logic [7:0]    NB8 = 8'(NBLOCKS);
  localparam logic [SW-1:0] NBS = SW'(NBLOCKS);
  localparam logic [AW-1:0] TOP = AW'(NBLOCKS - 1);

  cmd_t              cmd_q;
  logic [7:0]        pos_q;
  logic [WORD_W-1:0] opw_q;
  logic [8:0]        amt_q;
  logic [AW-1:0]     idx;

  logic [WORD_W-1:0] mem [NBLOCKS];
  logic [NBLOCKS-1:0] valid;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic              ok_a;
  logic              ok_b;
  logic              carry;

  logic              is_bit;
  logic              is_word;
  logic              is_shift;
  logic              over_cap;
  logic [7:0]        wsel;
  logic [AW-1:0]     waddr;

  logic [SW-1:0]     i_ext;
  logic [SW-1:0]     whole;
  logic [5:0]        part;
  logic              part_nz;
  logic [SW-1:0]     hi_idx;
  logic [SW-1:0]     lo_idx;
  logic              hi_ok;
  logic              lo_ok;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;

  logic [WORD_W-1:0] op_a;
  logic [WORD_W-1:0] op_b;
  logic [6:0]        inv;
  logic [WORD_W-1:0] sweep_word;

  logic [WORD_W-1:0] mask;
  logic              cin;
  logic [WORD_W:0]   sum;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] exec_res;
  logic              exec_cout;
  logic              exec_wr;

  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic              clear_all;

  // Decode of the held command.
  always_comb begin
    is_bit   = cmd_q inside {CMD_SETBIT, CMD_CLRBIT, CMD_GETBIT};
    is_word  = cmd_q inside {CMD_WRWORD, CMD_RDWORD, CMD_AND, CMD_OR, CMD_XOR,
                             CMD_ADD, CMD_SUB};
    is_shift = cmd_q inside {CMD_SHL, CMD_SHR};
    over_cap = CW'(amt_q) >= CAP;
    wsel     = is_bit ? {6'd0, pos_q[7:6]} : pos_q;
    waddr    = wsel[AW-1:0];
    stat.word_go    = (is_bit && ({6'd0, pos_q[7:6]} < NB8)) ||
                      (is_word && (pos_q < NB8));
    stat.sweep_go   = (is_shift && !over_cap) || (cmd_q == CMD_NOT);
    stat.sweep_last = (cmd_q == CMD_SHL) ? (idx == '0) : (idx == TOP);
  end

  // Source words of the sweep step at word idx.
  always_comb begin
    i_ext   = SW'(idx);
    whole   = SW'(amt_q[8:6]);
    part    = amt_q[5:0];
    part_nz = part != 6'd0;
    case (cmd_q)
      CMD_SHL: begin
        hi_idx = i_ext - whole;
        hi_ok  = i_ext >= whole;
        lo_idx = hi_idx - SW'(1);
        lo_ok  = (i_ext > whole) && part_nz;
      end
      CMD_SHR: begin
        hi_idx = i_ext + whole;
        hi_ok  = hi_idx < NBS;
        lo_idx = hi_idx + SW'(1);
        lo_ok  = (lo_idx < NBS) && part_nz;
      end
      default: begin
        hi_idx = i_ext;
        hi_ok  = 1'b1;
        lo_idx = i_ext;
        lo_ok  = 1'b0;
      end
    endcase
    if (ctrl.word_rd) begin
      addr_a = waddr;
    end else begin
      addr_a = hi_ok ? hi_idx[AW-1:0] : '0;
    end
    addr_b = lo_ok ? lo_idx[AW-1:0] : '0;
  end

  // Operand words; a word never written since the last clear reads as zero.
  always_comb begin
    op_a = ok_a ? rd_a : '0;
    op_b = ok_b ? rd_b : '0;
    inv  = 7'd64 - {1'b0, part};
    case (cmd_q)
      CMD_SHL: sweep_word = (op_a << part) | (op_b >> inv);
      CMD_SHR: sweep_word = (op_a >> part) | (op_b << inv);
      default: sweep_word = ~op_a;
    endcase
  end

  // Single word step.
  always_comb begin
    mask      = WORD_W'(1) << pos_q[5:0];
    cin       = (pos_q == 8'd0) ? 1'b0 : carry;
    sum       = {1'b0, op_a} + {1'b0, opw_q} + (WORD_W + 1)'(cin);
    diff      = {1'b0, op_a} - {1'b0, opw_q} - (WORD_W + 1)'(cin);
    exec_res  = '0;
    exec_cout = 1'b0;
    exec_wr   = 1'b0;
    case (cmd_q)
      CMD_SETBIT: begin
        exec_res = op_a | mask;
        exec_wr  = 1'b1;
      end
      CMD_CLRBIT: begin
        exec_res = op_a & ~mask;
        exec_wr  = 1'b1;
      end
      CMD_GETBIT: exec_res = WORD_W'(|(op_a & mask));
      CMD_WRWORD: begin
        exec_res = opw_q;
        exec_wr  = 1'b1;
      end
      CMD_RDWORD: exec_res = op_a;
      CMD_AND: begin
        exec_res = op_a & opw_q;
        exec_wr  = 1'b1;
      end
      CMD_OR: begin
        exec_res = op_a | opw_q;
        exec_wr  = 1'b1;
      end
      CMD_XOR: begin
        exec_res = op_a ^ opw_q;
        exec_wr  = 1'b1;
      end
      CMD_ADD: begin
        exec_res  = sum[WORD_W-1:0];
        exec_cout = sum[WORD_W];
        exec_wr   = 1'b1;
      end
      CMD_SUB: begin
        exec_res  = diff[WORD_W-1:0];
        exec_cout = diff[WORD_W];
        exec_wr   = 1'b1;
      end
      default: exec_res = '0;
    endcase
  end

  always_comb begin
    we        = (ctrl.word_exec && exec_wr) || ctrl.sweep_wr;
    wa        = ctrl.sweep_wr ? idx : waddr;
    wd        = ctrl.sweep_wr ? sweep_word : exec_res;
    clear_all = ctrl.finish && ((cmd_q == CMD_CLEAR) || (is_shift && over_cap));
  end

  // Hold the command word for the length of the operation.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= cmd_t'(command);
      pos_q <= position;
      opw_q <= operand_word;
      amt_q <= shift_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      idx <= (cmd_t'(command) == CMD_SHL) ? TOP : '0;
    end else if (ctrl.sweep_wr && !stat.sweep_last) begin
      idx <= (cmd_q == CMD_SHL) ? idx - AW'(1) : idx + AW'(1);
    end
  end

  // Word store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctrl.word_rd || ctrl.sweep_rd) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
      ok_a <= (ctrl.word_rd || hi_ok) && valid[addr_a];
      ok_b <= !ctrl.word_rd && lo_ok && valid[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear_all) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
    end else if (ctrl.word_exec && (cmd_q == CMD_ADD || cmd_q == CMD_SUB)) begin
      carry <= exec_cout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.word_exec || ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.word_exec) begin
      read_data <= exec_res;
      carry_out <= exec_cout;
    end else if (ctrl.finish) begin
      read_data <= '0;
      carry_out <= 1'b0;
    end
  end

  `WBVA_ASSERT(a_carry_cmd, done && carry_out, cmd_q == CMD_ADD || cmd_q == CMD_SUB, "carry out on a command without carry")
  `WBVA_ASSERT(a_getbit_narrow, done && cmd_q == CMD_GETBIT, read_data[WORD_W-1:1] == '0, "bit read wider than one bit")
  `WBVA_ASSERT(a_finish_zero, done && $past(ctrl.finish), read_data == '0 && !carry_out, "whole-vector command gave a nonzero word")

endmodule

`default_nettype wire

// ===== tb/tb_wide_bit_vector_alu.sv =====
// Self-checking testbench for the wide bit vector ALU: queued command words, scoreboard, watchdog.
`default_nettype none

module tb_wide_bit_vector_alu;
  import wbva_pkg::*;

  localparam int NB = 4;
  localparam int VEC_W = NB * WORD_W;
  // A shift or an inversion reads, then writes back, every word.
  localparam int SHIFT_LATENCY = 2 * NB + 3;
  localparam int DRAIN_CYCLES = SHIFT_LATENCY + 16;
  // The longest quiet stretch in a correct run is the longest hold-off plus a
  // shift, so this limit is many times over.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_WORDS = 1900;
  // No hold-offs once this few command words are left.
  localparam int CALM_TAIL = 150;

  // Codes with no function; the block must answer them with zeros.
  localparam logic [3:0] CMD_SPARE_LO = 4'd14;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] LOW_BIT = {{(WORD_W-1){1'b0}}, 1'b1};

  typedef struct {
    logic [3:0]        command;
    logic [7:0]        position;
    logic [WORD_W-1:0] operand_word;
    logic [8:0]        shift_amount;
  } command_word_t;

  typedef struct {
    logic [3:0]        command;
    logic [WORD_W-1:0] read_data;
    logic              carry_out;
  } result_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [3:0]        command = '0;
  logic [7:0]        position = '0;
  logic [WORD_W-1:0] operand_word = '0;
  logic [8:0]        shift_amount = '0;
  logic              busy;
  logic              done;
  logic [WORD_W-1:0] read_data;
  logic              carry_out;

  // Command words still to be driven, and results still to arrive.
  command_word_t command_words[$];
  result_word_t  result_words_due[$];

  // Shadow copy of the vector and of the chained carry or borrow.
  logic [WORD_W-1:0] vector_image [NB];
  logic              carry_image;

  // Chain operations, weighted toward add and subtract.
  logic [3:0] chain_ops [7] = '{CMD_AND, CMD_OR, CMD_XOR, CMD_ADD, CMD_ADD, CMD_SUB, CMD_SUB};
  logic [3:0] bit_ops [3] = '{CMD_SETBIT, CMD_CLRBIT, CMD_GETBIT};

  logic word_taken = 1'b0;
  int   hold_off = 0;
  int   calm_left = 0;
  int   stall_cycles = 0;
  int   fail_count = 0;
  int   words_accepted = 0;
  int   results_checked = 0;
  int   shifts_seen = 0;
  int   carries_seen = 0;

  wide_bit_vector_alu #(.NBLOCKS(NB)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .position     (position),
    .operand_word (operand_word),
    .shift_amount (shift_amount),
    .done         (done),
    .read_data    (read_data),
    .carry_out    (carry_out)
  );

  always #1 clk = ~clk;

  // Apply one command word to the shadow vector and return the result it owes.
  function automatic result_word_t vector_step(command_word_t cw);
    result_word_t      r;
    logic [VEC_W-1:0]  flat;
    logic [WORD_W:0]   wide;
    logic [WORD_W-1:0] bit_mask;
    logic              chain_in;
    int                bw;
    int                i;
    bit                bit_ok;
    bit                word_ok;
    r.command = cw.command;
    r.read_data = '0;
    r.carry_out = 1'b0;
    bw = cw.position / WORD_W;
    bit_ok = bw < NB;
    word_ok = cw.position < NB;
    bit_mask = LOW_BIT << cw.position[5:0];
    // Word 0 always opens a chain with no carry or borrow.
    chain_in = (cw.position == 0) ? 1'b0 : carry_image;
    case (cw.command)
      CMD_CLEAR: begin
        for (i = 0; i < NB; i++) vector_image[i] = '0;
      end
      CMD_SETBIT: begin
        if (bit_ok) begin
          vector_image[bw] |= bit_mask;
          r.read_data = vector_image[bw];
        end
      end
      CMD_CLRBIT: begin
        if (bit_ok) begin
          vector_image[bw] &= ~bit_mask;
          r.read_data = vector_image[bw];
        end
      end
      CMD_GETBIT: begin
        if (bit_ok) r.read_data = WORD_W'(|(vector_image[bw] & bit_mask));
      end
      CMD_WRWORD: begin
        if (word_ok) begin
          vector_image[cw.position] = cw.operand_word;
          r.read_data = cw.operand_word;
        end
      end
      CMD_RDWORD: begin
        if (word_ok) r.read_data = vector_image[cw.position];
      end
      CMD_SHL, CMD_SHR: begin
        // Shift the vector as one flat value; word 0 holds the low bits.
        for (i = 0; i < NB; i++) flat[i*WORD_W +: WORD_W] = vector_image[i];
        if (cw.shift_amount >= VEC_W) flat = '0;
        else if (cw.command == CMD_SHL) flat = flat << cw.shift_amount;
        else flat = flat >> cw.shift_amount;
        for (i = 0; i < NB; i++) vector_image[i] = flat[i*WORD_W +: WORD_W];
      end
      CMD_NOT: begin
        for (i = 0; i < NB; i++) vector_image[i] = ~vector_image[i];
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        if (word_ok) begin
          if (cw.command == CMD_AND) vector_image[cw.position] &= cw.operand_word;
          else if (cw.command == CMD_OR) vector_image[cw.position] |= cw.operand_word;
          else vector_image[cw.position] ^= cw.operand_word;
          r.read_data = vector_image[cw.position];
        end
      end
      CMD_ADD, CMD_SUB: begin
        if (word_ok) begin
          // Work one bit wider; the top bit is the carry, or the borrow on a wrap.
          if (cw.command == CMD_ADD)
            wide = {1'b0, vector_image[cw.position]} + {1'b0, cw.operand_word} + chain_in;
          else
            wide = {1'b0, vector_image[cw.position]} - {1'b0, cw.operand_word} - chain_in;
          vector_image[cw.position] = wide[WORD_W-1:0];
          carry_image = wide[WORD_W];
          r.read_data = wide[WORD_W-1:0];
          r.carry_out = wide[WORD_W];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void queue_word(logic [3:0] cmd, logic [7:0] pos,
                                     logic [WORD_W-1:0] opw, logic [8:0] amt);
    command_word_t cw;
    cw.command = cmd;
    cw.position = pos;
    cw.operand_word = opw;
    cw.shift_amount = amt;
    command_words = {command_words, cw};
  endfunction

  // Operand words lean toward the values that stress carries and borrows.
  function automatic logic [WORD_W-1:0] operand_pick();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return LOW_BIT;
      3: return TOP_BIT;
      4: return ALL_ONES - $urandom_range(0, 3);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Shift amounts lean toward zero, word boundaries and the capacity.
  function automatic logic [8:0] shift_pick();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 9'(VEC_W);
      2: return 9'($urandom_range(0, NB - 1) * WORD_W);
      3: return 9'($urandom_range(WORD_W - 2, WORD_W + 2));
      4: return 9'($urandom_range(VEC_W - 3, VEC_W));
      default: return 9'($urandom_range(0, VEC_W));
    endcase
  endfunction

  function automatic logic [8:0] any_amount();
    return 9'($urandom_range(0, VEC_W));
  endfunction

  // Driver: present the next command word at the falling edge, with random
  // hold-offs between words and calm stretches with none.
  always @(negedge clk) begin
    command_word_t cw;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (hold_off > 0) begin
        start <= 1'b0;
        hold_off--;
      end else if (command_words.size() != 0) begin
        cw = command_words.pop_front();
        start <= 1'b1;
        command <= cw.command;
        position <= cw.position;
        operand_word <= cw.operand_word;
        shift_amount <= cw.shift_amount;
        // Pick the hold-off that follows this word once it is taken.
        if (command_words.size() < CALM_TAIL) hold_off = 0;
        else if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
        else if ($urandom_range(0, 2) == 0) hold_off = $urandom_range(1, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results and predict accepted words at the rising edge.
  always @(posedge clk) begin
    result_word_t due;
    command_word_t cw;
    int k;
    if (rst) begin
      word_taken <= 1'b0;
      for (k = 0; k < NB; k++) vector_image[k] = '0;
      carry_image = 1'b0;
      stall_cycles = 0;
    end else begin
      word_taken <= start && !busy;
      // Check before predicting, so a stray result never eats a fresh expectation.
      if (done) begin
        if (result_words_due.size() == 0) begin
          $display("%0t: result with nothing pending: read_data %h carry_out %b",
                   $time, read_data, carry_out);
          fail_count++;
        end else begin
          due = result_words_due.pop_front();
          results_checked++;
          if (read_data !== due.read_data) begin
            $display("%0t: read_data mismatch, command %0d: expected %h, actual %h",
                     $time, due.command, due.read_data, read_data);
            fail_count++;
          end
          if (carry_out !== due.carry_out) begin
            $display("%0t: carry_out mismatch, command %0d: expected %b, actual %b",
                     $time, due.command, due.carry_out, carry_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        cw.command = command;
        cw.position = position;
        cw.operand_word = operand_word;
        cw.shift_amount = shift_amount;
        due = vector_step(cw);
        result_words_due = {result_words_due, due};
        words_accepted++;
        if (command == CMD_SHL || command == CMD_SHR) shifts_seen++;
        if (due.carry_out) carries_seen++;
      end
      // Watchdog: count cycles in which neither side moves a word.
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, result_words_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int target;
    int kind;
    int first;
    int n;
    int i;
    logic [3:0] op;

    // Directed opening: reset contents, field extremes, every command,
    // out-of-range words, zero and oversize shifts, carry and borrow chains.
    queue_word(CMD_RDWORD, 8'd0, ALL_ONES, 9'd0);
    queue_word(CMD_WRWORD, 8'd0, ALL_ONES, 9'd511 & 9'(VEC_W));
    queue_word(CMD_WRWORD, 8'(NB - 1), TOP_BIT | LOW_BIT, 9'd0);
    queue_word(CMD_WRWORD, 8'd255, 64'h0123_4567_89ab_cdef, 9'd0);
    queue_word(CMD_SETBIT, 8'd255, '0, 9'd0);
    queue_word(CMD_SETBIT, 8'd64, ALL_ONES, 9'd0);
    queue_word(CMD_CLRBIT, 8'd0, '0, 9'd0);
    queue_word(CMD_GETBIT, 8'd255, '0, 9'd0);
    queue_word(CMD_GETBIT, 8'd100, '0, 9'd0);
    queue_word(CMD_SHL, 8'd0, '0, 9'd1);
    queue_word(CMD_RDWORD, 8'(NB - 1), '0, 9'd0);
    queue_word(CMD_SHR, 8'd0, '0, 9'(VEC_W - 1));
    queue_word(CMD_RDWORD, 8'd0, '0, 9'd0);
    queue_word(CMD_SHL, 8'd0, '0, 9'd0);
    queue_word(CMD_SHR, 8'd0, '0, 9'(VEC_W));
    queue_word(CMD_NOT, 8'd0, '0, 9'd0);
    queue_word(CMD_ADD, 8'd0, ALL_ONES, 9'd0);
    queue_word(CMD_ADD, 8'd1, '0, 9'd0);
    queue_word(CMD_SUB, 8'd0, ALL_ONES, 9'd0);
    queue_word(CMD_SUB, 8'd1, ALL_ONES, 9'd0);
    queue_word(CMD_AND, 8'd2, TOP_BIT, 9'd0);
    queue_word(CMD_OR, 8'd3, LOW_BIT, 9'd0);
    queue_word(CMD_XOR, 8'd1, ALL_ONES, 9'd0);
    queue_word(CMD_SPARE_LO, 8'd0, ALL_ONES, 9'd5);
    queue_word(CMD_SPARE_HI, 8'd255, ALL_ONES, 9'd256);
    queue_word(CMD_CLEAR, 8'd0, '0, 9'd0);
    queue_word(CMD_ADD, 8'd255, ALL_ONES, 9'd0);

    // Random part: mostly well-formed word chains and load, shift, read-back
    // sequences, with bit traffic, stray indexes and unused codes as noise.
    target = command_words.size() + RANDOM_WORDS;
    while (command_words.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // Chain from word 0 upward; now and then start late or slip in noise.
        op = chain_ops[$urandom_range(0, 6)];
        first = ($urandom_range(0, 7) == 0) ? $urandom_range(1, NB - 1) : 0;
        for (i = first; i < NB; i++) begin
          if ($urandom_range(0, 11) == 0)
            queue_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       operand_pick(), any_amount());
          queue_word(op, 8'(i), operand_pick(), any_amount());
        end
      end else if (kind < 50) begin
        for (i = 0; i < NB; i++)
          queue_word(CMD_WRWORD, 8'(i), operand_pick(), any_amount());
      end else if (kind < 65) begin
        // Shift or invert, then read every word back to expose the result.
        case ($urandom_range(0, 4))
          0, 1: op = CMD_SHL;
          2, 3: op = CMD_SHR;
          default: op = CMD_NOT;
        endcase
        queue_word(op, 8'($urandom_range(0, 255)), {$urandom, $urandom}, shift_pick());
        for (i = 0; i < NB; i++)
          queue_word(CMD_RDWORD, 8'(i), {$urandom, $urandom}, any_amount());
      end else if (kind < 85) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          queue_word(bit_ops[$urandom_range(0, 2)], 8'($urandom_range(0, 255)),
                     {$urandom, $urandom}, any_amount());
      end else if (kind < 95) begin
        op = $urandom_range(0, 1) ? CMD_RDWORD : CMD_WRWORD;
        queue_word(op, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, NB - 1)),
                   operand_pick(), any_amount());
      end else begin
        case ($urandom_range(0, 3))
          0: op = CMD_CLEAR;
          1: op = CMD_SPARE_LO;
          2: op = CMD_SPARE_HI;
          default: op = 4'($urandom_range(0, 15));
        endcase
        queue_word(op, 8'($urandom_range(0, 255)), {$urandom, $urandom}, any_amount());
      end
    end

    // Hold reset, then release it away from the sampling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every word driven and taken, every result back, then a margin
    // for anything stray.
    while (command_words.size() != 0 || start || result_words_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d command words (%0d shifts), %0d results checked",
             words_accepted, shifts_seen, results_checked);
    $display("%0d add or subtract steps ended in a carry or borrow, %0d mismatches",
             carries_seen, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
